// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/i2cm_pkg.sv =====
// shared types and constants for the i2c byte master
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  localparam int TICK_COUNTER_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH            = 2;
  localparam int HPT_W                  = 16;

  localparam logic [HPT_W-1:0] HALF_PERIOD_RESET = 16'd100;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_START = 2'd1;
  localparam logic [1:0] STAT_NACK     = 2'd2;

  // one tick as it travels from front to back
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] write_data;
    logic       send_ack;
    logic       scl;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== src/i2cm_fifo.sv =====
// short queue between the front and the bus engine
`timescale 1ns / 1ps
`default_nettype none

module i2cm_fifo #(
  parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire i2cm_pkg::item_t   item_in,
  input  wire logic              pop,
  output i2cm_pkg::item_t        item_out,
  output i2cm_pkg::q_stat_t      stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  i2cm_pkg::item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign item_out   = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == FULL);

endmodule

`default_nettype wire

// ===== src/i2cm_front.sv =====
// input side: takes a word each tick and decodes the command
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        mode,
  input  wire logic [7:0]        write_data,
  input  wire logic              send_ack,
  input  wire logic              scl_in,
  input  wire logic              sda_in,
  input  wire i2cm_pkg::q_stat_t stat,
  output logic                   push,
  output i2cm_pkg::item_t        item
);

  logic [2:0] cmd;

  // unused mode codes fold into no command
  always_comb begin
    case (mode)
      i2cm_pkg::CMD_START: cmd = i2cm_pkg::CMD_START;
      i2cm_pkg::CMD_STOP:  cmd = i2cm_pkg::CMD_STOP;
      i2cm_pkg::CMD_WRITE: cmd = i2cm_pkg::CMD_WRITE;
      i2cm_pkg::CMD_READ:  cmd = i2cm_pkg::CMD_READ;
      default:             cmd = i2cm_pkg::CMD_NONE;
    endcase
  end

  assign in_stall        = stat.full;
  assign push            = in_valid && !stat.full;
  assign item.cmd        = cmd;
  assign item.write_data = write_data;
  assign item.send_ack   = send_ack;
  assign item.scl        = scl_in;
  assign item.sda        = sda_in;

endmodule

`default_nettype wire

// ===== src/i2cm_engine.sv =====
// back side: bit-level bus sequencer, one tick per queued word
`timescale 1ns / 1ps
`default_nettype none

module i2cm_engine #(
  parameter int TICK_COUNTER_WIDTH = i2cm_pkg::TICK_COUNTER_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [i2cm_pkg::HPT_W-1:0] cfg_wdata,
  input  wire i2cm_pkg::item_t            item,
  input  wire i2cm_pkg::q_stat_t          stat,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            scl_release,
  output logic                            sda_release,
  output logic                            busy_res,
  output logic                            done_res,
  output logic [1:0]                      status,
  output logic [7:0]                      read_data
);

  localparam int W    = TICK_COUNTER_WIDTH;
  localparam int CMPW = ((W > i2cm_pkg::HPT_W) ? W : i2cm_pkg::HPT_W) + 1;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_FIRST  = 3'd1;
  localparam logic [2:0] PH_WAIT   = 3'd2;
  localparam logic [2:0] PH_SECOND = 3'd3;
  localparam logic [2:0] PH_TAIL   = 3'd4;

  logic [i2cm_pkg::HPT_W-1:0] half_period;
  logic [2:0] phase, phase_next;
  logic [2:0] cmd, cmd_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [W-1:0] count, count_next;
  logic ack_choice, ack_choice_next;
  logic scl_drive, scl_drive_next;
  logic sda_drive, sda_drive_next;
  logic [1:0] last_status, last_status_next;
  logic [7:0] received, received_next;
  logic done, done_next;

  logic [CMPW-1:0] cnt_inc;
  logic [CMPW-1:0] limit;
  logic            dly_end;
  logic [W-1:0]    cnt_adv;

  // zero half period counts as one tick; a full counter ends the delay
  assign cnt_inc = CMPW'(count) + 1'b1;
  assign limit   = (half_period == '0) ? CMPW'(1) : CMPW'(half_period);
  assign dly_end = (cnt_inc >= limit) || (&count);
  assign cnt_adv = count + 1'b1;

  assign pop = !stat.empty && (!out_valid || !out_stall);

  always_comb begin
    phase_next       = phase;
    cmd_next         = cmd;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    count_next       = count;
    ack_choice_next  = ack_choice;
    scl_drive_next   = scl_drive;
    sda_drive_next   = sda_drive;
    last_status_next = last_status;
    received_next    = received;
    done_next        = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (item.cmd != i2cm_pkg::CMD_NONE) begin
          cmd_next       = item.cmd;
          bit_index_next = '0;
          count_next     = '0;
          phase_next     = PH_FIRST;
          case (item.cmd)
            i2cm_pkg::CMD_START: sda_drive_next = 1'b1;
            i2cm_pkg::CMD_STOP:  sda_drive_next = 1'b0;
            i2cm_pkg::CMD_WRITE: begin
              sda_drive_next  = item.write_data[7];
              shift_byte_next = {item.write_data[6:0], 1'b0};
            end
            default: begin
              sda_drive_next  = 1'b1;
              shift_byte_next = '0;
              ack_choice_next = item.send_ack;
            end
          endcase
        end
      end
      PH_FIRST: begin
        if (dly_end) begin
          count_next     = '0;
          scl_drive_next = 1'b1;
          phase_next     = PH_WAIT;
        end else begin
          count_next = cnt_adv;
        end
      end
      PH_WAIT: begin
        // clock stretching: hold until the slave lets scl go high
        if (item.scl) begin
          count_next = '0;
          phase_next = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (!dly_end) begin
          count_next = cnt_adv;
        end else begin
          count_next = '0;
          case (cmd)
            i2cm_pkg::CMD_START: begin
              if (!item.sda) begin
                sda_drive_next   = 1'b1;
                last_status_next = i2cm_pkg::STAT_NO_START;
                done_next        = 1'b1;
              end else begin
                sda_drive_next = 1'b0;
                phase_next     = PH_TAIL;
              end
            end
            i2cm_pkg::CMD_STOP: begin
              sda_drive_next = 1'b1;
              phase_next     = PH_TAIL;
            end
            i2cm_pkg::CMD_WRITE: begin
              scl_drive_next = 1'b0;
              if (!bit_index[3]) begin
                bit_index_next = bit_index + 1'b1;
                if (bit_index != 4'd7) begin
                  sda_drive_next  = shift_byte[7];
                  shift_byte_next = {shift_byte[6:0], 1'b0};
                end else begin
                  sda_drive_next = 1'b1;
                end
                phase_next = PH_FIRST;
              end else begin
                last_status_next = item.sda ? i2cm_pkg::STAT_NACK : i2cm_pkg::STAT_OK;
                done_next        = 1'b1;
              end
            end
            default: begin
              scl_drive_next = 1'b0;
              if (!bit_index[3]) begin
                shift_byte_next = {shift_byte[6:0], item.sda};
                bit_index_next  = bit_index + 1'b1;
                if (bit_index == 4'd7) begin
                  sda_drive_next = !ack_choice;
                end
                phase_next = PH_FIRST;
              end else begin
                sda_drive_next   = 1'b1;
                received_next    = shift_byte;
                last_status_next = i2cm_pkg::STAT_OK;
                done_next        = 1'b1;
              end
            end
          endcase
        end
      end
      PH_TAIL: begin
        if (dly_end) begin
          count_next = '0;
          if (cmd == i2cm_pkg::CMD_START) begin
            scl_drive_next = 1'b0;
          end
          last_status_next = i2cm_pkg::STAT_OK;
          done_next        = 1'b1;
        end else begin
          count_next = cnt_adv;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    if (done_next) begin
      phase_next = PH_IDLE;
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cm_pkg::HALF_PERIOD_RESET;
    end else if (cfg_we) begin
      half_period <= cfg_wdata;
    end
  end

  // state only moves when a word is popped, so a stalled result holds
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      cmd         <= i2cm_pkg::CMD_NONE;
      bit_index   <= '0;
      shift_byte  <= '0;
      count       <= '0;
      ack_choice  <= 1'b0;
      scl_drive   <= 1'b1;
      sda_drive   <= 1'b1;
      last_status <= i2cm_pkg::STAT_OK;
      received    <= '0;
      done        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        cmd         <= cmd_next;
        bit_index   <= bit_index_next;
        shift_byte  <= shift_byte_next;
        count       <= count_next;
        ack_choice  <= ack_choice_next;
        scl_drive   <= scl_drive_next;
        sda_drive   <= sda_drive_next;
        last_status <= last_status_next;
        received    <= received_next;
        done        <= done_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign scl_release = scl_drive;
  assign sda_release = sda_drive;
  assign busy_res    = (phase != PH_IDLE);
  assign done_res    = done;
  assign status      = last_status;
  assign read_data   = received;

endmodule

`default_nettype wire

// ===== src/i2c_byte_master.sv =====
// i2c byte master: decoding front, word queue and bus sequencer
// an accepted word is queued, then its result word is registered in the engine
// throughput: one word per cycle when not stalled; each is one sequencer tick
// the queue holds two words and fills only while the result side stalls
// reset: synchronous rst, lines released, sequencer idle, half period 100 ticks
`timescale 1ns / 1ps
`default_nettype none

module i2c_byte_master #(
  parameter int TICK_COUNTER_WIDTH = i2cm_pkg::TICK_COUNTER_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [i2cm_pkg::HPT_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [2:0]                 mode,
  input  wire logic [7:0]                 write_data,
  input  wire logic                       send_ack,
  input  wire logic                       scl_in,
  input  wire logic                       sda_in,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            scl_release,
  output logic                            sda_release,
  output logic                            busy_res,
  output logic                            done_res,
  output logic [1:0]                      status,
  output logic [7:0]                      read_data
);

  i2cm_pkg::item_t   front_item;
  i2cm_pkg::item_t   head_item;
  i2cm_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  i2cm_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .write_data (write_data),
    .send_ack   (send_ack),
    .scl_in     (scl_in),
    .sda_in     (sda_in),
    .stat       (q_stat),
    .push       (push),
    .item       (front_item)
  );

  i2cm_fifo #(
    .DEPTH (i2cm_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (front_item),
    .pop      (pop),
    .item_out (head_item),
    .stat     (q_stat)
  );

  i2cm_engine #(
    .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item        (head_item),
    .stat        (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scl_release (scl_release),
    .sda_release (sda_release),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .status      (status),
    .read_data   (read_data)
  );

endmodule

`default_nettype wire

// ===== src/i2cm_checker.sv =====
// port-level checks for the i2c byte master, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module i2cm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       scl_release,
  input wire logic       sda_release,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic [1:0] status,
  input wire logic [7:0] read_data
);

  // a finishing word always shows the sequencer back at idle
  `CHK_SAME(a_done_idle, out_valid && done_res, !busy_res, "done while still busy")

  `CHK_SAME(a_status_code, out_valid, status != 2'd3, "status code out of range")

  // a failed start leaves both lines released
  `CHK_SAME(a_start_fail_lines, out_valid && done_res && (status == i2cm_pkg::STAT_NO_START),
    scl_release && sda_release, "failed start left a line driven")

  `CHK_NEXT(a_hold_stalled, out_valid && out_stall,
    out_valid && $stable(scl_release) && $stable(sda_release) && $stable(busy_res)
    && $stable(done_res) && $stable(status) && $stable(read_data),
    "stalled result word changed")

endmodule

bind i2c_byte_master i2cm_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .scl_release (scl_release),
  .sda_release (sda_release),
  .busy_res    (busy_res),
  .done_res    (done_res),
  .status      (status),
  .read_data   (read_data)
);

`default_nettype wire
